// File: src/byte_code_register_machine_unit_defines.svh
// Assertion macros used by the register machine top level.
`ifndef BYTE_CODE_REGISTER_MACHINE_UNIT_DEFINES_SVH
`define BYTE_CODE_REGISTER_MACHINE_UNIT_DEFINES_SVH
// Checks that a condition implies a consequence at the same edge.
`define BCRM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Checks that a condition implies a consequence at the next edge.
`define BCRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: src/bcrm_pkg.sv
// Types and constants of the byte-code register machine.
package bcrm_pkg;
    localparam logic [2:0] OP_LOAD_PROG = 3'd0;
    localparam logic [2:0] OP_WRITE_DATA = 3'd1;
    localparam logic [2:0] OP_READ_DATA = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STEP = 3'd4;

    localparam logic [7:0] OPC_HLT = 8'd0;
    localparam logic [7:0] OPC_MOVLR = 8'd1;
    localparam logic [7:0] OPC_MOVRR = 8'd2;
    localparam logic [7:0] OPC_MOVMR = 8'd3;
    localparam logic [7:0] OPC_MOVRM = 8'd4;
    localparam logic [7:0] OPC_ADD = 8'd5;
    localparam logic [7:0] OPC_SUB = 8'd6;
    localparam logic [7:0] OPC_MULT = 8'd7;
    localparam logic [7:0] OPC_DIV = 8'd8;
    localparam logic [7:0] OPC_CMP = 8'd9;
    localparam logic [7:0] OPC_JMP = 8'd10;
    localparam logic [7:0] OPC_JEQ = 8'd11;
    localparam logic [7:0] OPC_JNE = 8'd12;
    localparam logic [7:0] OPC_JLT = 8'd13;
    localparam logic [7:0] OPC_JLE = 8'd14;
    localparam logic [7:0] OPC_JGT = 8'd15;
    localparam logic [7:0] OPC_JGE = 8'd16;

    localparam int NUM_REGS = 7;
    localparam logic [2:0] RIDX_IP = 3'd0;
    localparam logic [2:0] RIDX_RE = 3'd1;
    localparam logic [2:0] RIDX_CR = 3'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [15:0] addr;
        logic [7:0] data;
    } bcrm_in_t;

    typedef struct packed {
        logic step_status;
        logic divide_by_zero;
        logic [7:0] read_byte;
        logic [15:0] ip_value;
        logic [15:0] rem_value;
        logic [15:0] cmp_value;
        logic [15:0] r1_value;
        logic [15:0] r2_value;
        logic [15:0] r3_value;
        logic [15:0] r4_value;
    } bcrm_out_t;
endpackage

// File: src/bcrm_in_if.sv
// Handshake channel that carries input items.
interface bcrm_in_if;
    import bcrm_pkg::*;
    logic valid;
    logic ready;
    logic [2:0] op;
    logic [15:0] addr;
    logic [7:0] data;
    modport source (output valid, output op, output addr, output data, input ready);
    modport sink (input valid, input op, input addr, input data, output ready);
endinterface

// File: src/bcrm_out_if.sv
// Handshake channel that carries result items.
interface bcrm_out_if;
    logic valid;
    logic ready;
    logic step_status;
    logic divide_by_zero;
    logic [7:0] read_byte;
    logic [15:0] ip_value;
    logic [15:0] rem_value;
    logic [15:0] cmp_value;
    logic [15:0] r1_value;
    logic [15:0] r2_value;
    logic [15:0] r3_value;
    logic [15:0] r4_value;
    modport source (output valid, output step_status, output divide_by_zero,
        output read_byte, output ip_value, output rem_value, output cmp_value,
        output r1_value, output r2_value, output r3_value, output r4_value, input ready);
    modport sink (input valid, input step_status, input divide_by_zero,
        input read_byte, input ip_value, input rem_value, input cmp_value,
        input r1_value, input r2_value, input r3_value, input r4_value, output ready);
endinterface

// File: src/bcrm_queue.sv
// Two-entry queue of items between the front and back parts.
module bcrm_queue
    import bcrm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic push,
    input bcrm_in_t push_item,
    output logic full,
    input logic pop,
    output logic not_empty,
    output bcrm_in_t pop_item
);
    bcrm_in_t entry_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

// File: src/bcrm_divider.sv
// Restoring 16-bit divider that yields one quotient bit per cycle.
module bcrm_divider
    import bcrm_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic [15:0] dividend,
    input logic [15:0] divisor,
    output logic busy,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);
    logic [15:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [4:0] cnt_reg;
    logic [16:0] shifted;
    logic [17:0] diff;

    assign busy = (cnt_reg != 5'd0);
    assign quotient = quo_reg;
    assign remainder = rem_reg[15:0];
    assign shifted = {rem_reg[15:0], quo_reg[15]};
    assign diff = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else if (start)
        begin
            cnt_reg <= 5'd16;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 17'd0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            if (!diff[17])
            begin
                rem_reg <= diff[16:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end
endmodule

// File: src/bcrm_back.sv
// Execution part: program and data stores, registers and the instruction sequencer.
module bcrm_back
    import bcrm_pkg::*;
#(
    parameter int PROG_ADDR_BITS = 12,
    parameter int DATA_ADDR_BITS = 16
)
(
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input bcrm_in_t item,
    output logic item_pop,
    output logic res_valid,
    output bcrm_out_t res,
    input logic res_ready,
    output logic clearing,
    output logic halted
);
    localparam logic [4:0] ST_CLEAR = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_FETCH = 5'd2;
    localparam logic [4:0] ST_FWAIT = 5'd3;
    localparam logic [4:0] ST_EXEC = 5'd4;
    localparam logic [4:0] ST_DRD = 5'd5;
    localparam logic [4:0] ST_DRDW = 5'd6;
    localparam logic [4:0] ST_DWR = 5'd7;
    localparam logic [4:0] ST_DIV = 5'd8;
    localparam logic [4:0] ST_RDB = 5'd9;
    localparam logic [4:0] ST_DONE = 5'd10;
    localparam logic [4:0] ST_DIVW = 5'd11;

    logic [7:0] prog_mem [2**PROG_ADDR_BITS];
    logic [7:0] data_mem [2**DATA_ADDR_BITS];

    logic [4:0] state_reg;
    logic [DATA_ADDR_BITS:0] clr_reg;
    logic [15:0] regs_reg [NUM_REGS];
    logic halted_reg;
    logic [2:0] nbytes_reg;
    logic [2:0] bidx_reg;
    logic [7:0] ib_reg [4];
    logic [7:0] prd_reg;
    logic [7:0] drd_reg;
    logic [15:0] daddr_reg;
    logic [15:0] dword_reg;
    logic dsec_reg;
    logic dz_reg;
    logic status_reg;
    logic [7:0] rbyte_reg;
    logic res_valid_reg;
    logic div_start;
    logic div_busy;
    logic [15:0] div_q;
    logic [15:0] div_r;
    logic [15:0] opa;
    logic [15:0] opb;
    logic [15:0] cr;
    logic jump_ok;
    logic [31:0] prod;
    logic [15:0] wval;
    logic wen;
    logic [2:0] widx;
    logic [DATA_ADDR_BITS-1:0] dwa;
    logic [7:0] dwd;
    logic dwe;
    logic [DATA_ADDR_BITS-1:0] dra;
    logic [2:0] nb;

    function automatic logic [15:0] rd_reg(input logic [7:0] idx, input logic [15:0] r0,
        input logic [15:0] r1, input logic [15:0] r2, input logic [15:0] r3,
        input logic [15:0] r4, input logic [15:0] r5, input logic [15:0] r6);
        logic [15:0] v;
        case (idx)
            8'd0: v = r0;
            8'd1: v = r1;
            8'd2: v = r2;
            8'd3: v = r3;
            8'd4: v = r4;
            8'd5: v = r5;
            8'd6: v = r6;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    assign clearing = (state_reg == ST_CLEAR);
    assign halted = halted_reg;
    assign item_pop = (state_reg == ST_IDLE) && item_valid && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign cr = regs_reg[RIDX_CR];

    assign res.step_status = status_reg;
    assign res.divide_by_zero = dz_reg;
    assign res.read_byte = rbyte_reg;
    assign res.ip_value = regs_reg[0];
    assign res.rem_value = regs_reg[1];
    assign res.cmp_value = regs_reg[2];
    assign res.r1_value = regs_reg[3];
    assign res.r2_value = regs_reg[4];
    assign res.r3_value = regs_reg[5];
    assign res.r4_value = regs_reg[6];

    always_comb
    begin
        case (ib_reg[0])
            OPC_MOVLR, OPC_MOVMR, OPC_MOVRM: nb = 3'd4;
            OPC_MOVRR, OPC_CMP, OPC_JMP, OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JLE, OPC_JGT,
            OPC_JGE: nb = 3'd3;
            OPC_ADD, OPC_SUB, OPC_MULT, OPC_DIV: nb = 3'd4;
            default: nb = 3'd1;
        endcase
    end

    always_comb
    begin
        case (ib_reg[0])
            OPC_MOVRR, OPC_CMP: opa = rd_reg(ib_reg[2], regs_reg[0], regs_reg[1],
                regs_reg[2], regs_reg[3], regs_reg[4], regs_reg[5], regs_reg[6]);
            OPC_MOVRM: opa = rd_reg(ib_reg[3], regs_reg[0], regs_reg[1],
                regs_reg[2], regs_reg[3], regs_reg[4], regs_reg[5], regs_reg[6]);
            default: opa = rd_reg(ib_reg[2], regs_reg[0], regs_reg[1],
                regs_reg[2], regs_reg[3], regs_reg[4], regs_reg[5], regs_reg[6]);
        endcase
        if (ib_reg[0] == OPC_CMP)
        begin
            opa = rd_reg(ib_reg[1], regs_reg[0], regs_reg[1], regs_reg[2],
                regs_reg[3], regs_reg[4], regs_reg[5], regs_reg[6]);
            opb = rd_reg(ib_reg[2], regs_reg[0], regs_reg[1], regs_reg[2],
                regs_reg[3], regs_reg[4], regs_reg[5], regs_reg[6]);
        end
        else
        begin
            opb = rd_reg(ib_reg[3], regs_reg[0], regs_reg[1], regs_reg[2],
                regs_reg[3], regs_reg[4], regs_reg[5], regs_reg[6]);
        end
    end

    assign prod = opa * opb;

    always_comb
    begin
        case (ib_reg[0])
            OPC_JMP: jump_ok = 1'b1;
            OPC_JEQ: jump_ok = (cr == 16'd0);
            OPC_JNE: jump_ok = (cr != 16'd0);
            OPC_JLT: jump_ok = (cr == 16'd1);
            OPC_JLE: jump_ok = (cr[7:0] == 8'd0) || (cr[7:0] == 8'd1);
            OPC_JGT: jump_ok = (cr[7:0] == 8'd2);
            OPC_JGE: jump_ok = (cr[7:0] == 8'd0) || (cr[7:0] == 8'd2);
            default: jump_ok = 1'b0;
        endcase
    end

    assign div_start = (state_reg == ST_EXEC) && (ib_reg[0] == OPC_DIV) && (opb != 16'd0);

    bcrm_divider u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(opa),
        .divisor(opb),
        .busy(div_busy),
        .quotient(div_q),
        .remainder(div_r)
    );

    always_ff @(posedge clk)
    begin
        prd_reg <= prog_mem[regs_reg[0][PROG_ADDR_BITS-1:0]];
        if ((state_reg == ST_IDLE) && item_pop && (item.op == OP_LOAD_PROG))
        begin
            prog_mem[item.addr[PROG_ADDR_BITS-1:0]] <= item.data;
        end
    end

    always_comb
    begin
        dwe = 1'b0;
        dwa = item.addr[DATA_ADDR_BITS-1:0];
        dwd = item.data;
        if (state_reg == ST_CLEAR)
        begin
            dwe = 1'b1;
            dwa = clr_reg[DATA_ADDR_BITS-1:0];
            dwd = 8'd0;
        end
        else if (state_reg == ST_DWR)
        begin
            dwe = 1'b1;
            dwa = daddr_reg[DATA_ADDR_BITS-1:0];
            dwd = dsec_reg ? dword_reg[7:0] : dword_reg[15:8];
        end
        else if (item_pop && (item.op == OP_WRITE_DATA))
        begin
            dwe = 1'b1;
        end
        dra = (state_reg == ST_IDLE) ? item.addr[DATA_ADDR_BITS-1:0]
            : daddr_reg[DATA_ADDR_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        drd_reg <= data_mem[dra];
        if (dwe)
        begin
            data_mem[dwa] <= dwd;
        end
    end

    always_comb
    begin
        wen = 1'b0;
        widx = 3'd0;
        wval = 16'd0;
        case (ib_reg[0])
            OPC_MOVLR:
            begin
                wen = 1'b1;
                wval = {ib_reg[2], ib_reg[3]};
            end
            OPC_MOVRR:
            begin
                wen = 1'b1;
                wval = opa;
            end
            OPC_ADD:
            begin
                wen = 1'b1;
                wval = opa + opb;
            end
            OPC_SUB:
            begin
                wen = 1'b1;
                wval = opa - opb;
            end
            OPC_MULT:
            begin
                wen = 1'b1;
                wval = prod[15:0];
            end
            default:
            begin
                wen = 1'b0;
            end
        endcase
        widx = ib_reg[1][2:0];
        if (ib_reg[1] > 8'd6)
        begin
            wen = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= 16'd0;
            end
            halted_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            status_reg <= 1'b0;
            dz_reg <= 1'b0;
            rbyte_reg <= 8'd0;
            nbytes_reg <= 3'd0;
            bidx_reg <= 3'd0;
            dsec_reg <= 1'b0;
            daddr_reg <= 16'd0;
            dword_reg <= 16'd0;
            for (int i = 0; i < 4; i++)
            begin
                ib_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg[DATA_ADDR_BITS-1:0] == {DATA_ADDR_BITS{1'b1}})
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item_pop)
                    begin
                        status_reg <= 1'b0;
                        dz_reg <= 1'b0;
                        rbyte_reg <= 8'd0;
                        case (item.op)
                            OP_READ_DATA:
                            begin
                                daddr_reg <= item.addr;
                                state_reg <= ST_RDB;
                            end
                            OP_START:
                            begin
                                regs_reg[0] <= 16'd0;
                                res_valid_reg <= 1'b1;
                            end
                            OP_STEP:
                            begin
                                if (halted_reg)
                                begin
                                    status_reg <= 1'b1;
                                    res_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    bidx_reg <= 3'd0;
                                    nbytes_reg <= 3'd1;
                                    state_reg <= ST_FWAIT;
                                end
                            end
                            default: res_valid_reg <= 1'b1;
                        endcase
                    end
                end
                ST_RDB:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    rbyte_reg <= drd_reg;
                    res_valid_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_FWAIT:
                begin
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    ib_reg[bidx_reg[1:0]] <= prd_reg;
                    regs_reg[0] <= regs_reg[0] + 16'd1;
                    if (bidx_reg == 3'd0)
                    begin
                        nbytes_reg <= 3'd0;
                        bidx_reg <= 3'd1;
                        state_reg <= ST_EXEC;
                    end
                    else if (bidx_reg + 3'd1 == nbytes_reg)
                    begin
                        nbytes_reg <= 3'd0;
                        bidx_reg <= 3'd4;
                        state_reg <= ST_EXEC;
                    end
                    else
                    begin
                        bidx_reg <= bidx_reg + 3'd1;
                        state_reg <= ST_FWAIT;
                    end
                end
                ST_EXEC:
                begin
                    if (bidx_reg == 3'd1)
                    begin
                        if (nb == 3'd1)
                        begin
                            halted_reg <= 1'b1;
                            status_reg <= 1'b1;
                            res_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            nbytes_reg <= nb;
                            state_reg <= ST_FWAIT;
                        end
                    end
                    else
                    begin
                        case (ib_reg[0])
                            OPC_MOVMR:
                            begin
                                daddr_reg <= {ib_reg[2], ib_reg[3]};
                                dsec_reg <= 1'b0;
                                state_reg <= ST_DRD;
                            end
                            OPC_MOVRM:
                            begin
                                daddr_reg <= {ib_reg[1], ib_reg[2]};
                                dword_reg <= opa;
                                dsec_reg <= 1'b0;
                                state_reg <= ST_DWR;
                            end
                            OPC_DIV:
                            begin
                                if (opb == 16'd0)
                                begin
                                    dz_reg <= 1'b1;
                                    if (ib_reg[1] <= 8'd6)
                                    begin
                                        regs_reg[ib_reg[1][2:0]] <= 16'hFFFF;
                                    end
                                    regs_reg[RIDX_RE] <= opa;
                                    res_valid_reg <= 1'b1;
                                    state_reg <= ST_IDLE;
                                end
                                else
                                begin
                                    state_reg <= ST_DIVW;
                                end
                            end
                            OPC_CMP:
                            begin
                                regs_reg[RIDX_CR] <= (opa == opb) ? 16'd0
                                    : ((opa < opb) ? 16'd1 : 16'd2);
                                res_valid_reg <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            OPC_JMP, OPC_JEQ, OPC_JNE, OPC_JLT, OPC_JLE, OPC_JGT, OPC_JGE:
                            begin
                                if (jump_ok)
                                begin
                                    regs_reg[0] <= {ib_reg[1], ib_reg[2]};
                                end
                                res_valid_reg <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            default:
                            begin
                                if (wen)
                                begin
                                    regs_reg[widx] <= wval;
                                end
                                res_valid_reg <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIVW:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!div_busy)
                    begin
                        if (ib_reg[1] <= 8'd6)
                        begin
                            regs_reg[ib_reg[1][2:0]] <= div_q;
                        end
                        regs_reg[RIDX_RE] <= div_r;
                        res_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DRD:
                begin
                    state_reg <= ST_DRDW;
                end
                ST_DRDW:
                begin
                    if (!dsec_reg)
                    begin
                        dword_reg[15:8] <= drd_reg;
                        daddr_reg <= daddr_reg + 16'd1;
                        dsec_reg <= 1'b1;
                        state_reg <= ST_DRD;
                    end
                    else
                    begin
                        if (ib_reg[1] <= 8'd6)
                        begin
                            regs_reg[ib_reg[1][2:0]] <= {dword_reg[15:8], drd_reg};
                        end
                        res_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DWR:
                begin
                    if (!dsec_reg)
                    begin
                        daddr_reg <= daddr_reg + 16'd1;
                        dsec_reg <= 1'b1;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: src/byte_code_register_machine_unit.sv
// Top level of the byte-code register machine.
// The execution part takes items one at a time; a step fetches the instruction bytes, then executes.
// Fetch reads each program byte through a wait state; a nonzero divisor starts the divider.
// After reset the data store is cleared, with no item taken.
// Reset clears registers and the halted state; program bytes stay undefined.
`include "byte_code_register_machine_unit_defines.svh"
module byte_code_register_machine_unit
    import bcrm_pkg::*;
#(
    parameter int PROG_ADDR_BITS = 12,
    parameter int DATA_ADDR_BITS = 16
)
(
    input logic clk,
    input logic rst_n,
    bcrm_in_if.sink in_ch,
    bcrm_out_if.source out_ch
);
    bcrm_in_t in_item;
    bcrm_in_t q_item;
    bcrm_out_t res;
    logic q_full;
    logic q_ne;
    logic q_pop;
    logic push;
    logic clearing;
    logic halted;

    assign in_item.op = in_ch.op;
    assign in_item.addr = in_ch.addr;
    assign in_item.data = in_ch.data;
    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;

    bcrm_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(in_item),
        .full(q_full),
        .pop(q_pop),
        .not_empty(q_ne),
        .pop_item(q_item)
    );

    bcrm_back #(
        .PROG_ADDR_BITS(PROG_ADDR_BITS),
        .DATA_ADDR_BITS(DATA_ADDR_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(q_ne),
        .item(q_item),
        .item_pop(q_pop),
        .res_valid(out_ch.valid),
        .res(res),
        .res_ready(out_ch.ready),
        .clearing(clearing),
        .halted(halted)
    );

    assign out_ch.step_status = res.step_status;
    assign out_ch.divide_by_zero = res.divide_by_zero;
    assign out_ch.read_byte = res.read_byte;
    assign out_ch.ip_value = res.ip_value;
    assign out_ch.rem_value = res.rem_value;
    assign out_ch.cmp_value = res.cmp_value;
    assign out_ch.r1_value = res.r1_value;
    assign out_ch.r2_value = res.r2_value;
    assign out_ch.r3_value = res.r3_value;
    assign out_ch.r4_value = res.r4_value;

    `BCRM_ASSERT_IMPL(a_no_pop_clear, clearing, !q_pop)
    `BCRM_ASSERT_IMPL(a_no_result_clear, clearing, !out_ch.valid)
    `BCRM_ASSERT_NEXT(a_halt_sticky, halted, halted)
endmodule
